### hw/rtl/wcm_pkg.sv
// Shared types, constants and saturation helper for the wavelet coding modem.
package wcm_pkg;

   localparam int GROUP_SIZE_DEF = 4;
   localparam int GENUS_DEF = 4;
   localparam int ACC_W = 48;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_DATA  = 2'd1,
      OP_FLUSH = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      CMD_LOAD  = 3'b001,
      CMD_DATA  = 3'b010,
      CMD_FLUSH = 3'b100
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [1:0]         row;
      logic [3:0]         col;
      logic signed [7:0]  cval;
      logic signed [15:0] dval;
   } cmd_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               ovf;
   } sat_type;

   function automatic sat_type sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      sat_type s;
      hi = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
      lo = {{(ACC_W-31){1'b1}}, 31'd0};
      if (v > hi) begin
         s.value = 32'sh7FFF_FFFF;
         s.ovf   = 1'b1;
      end else if (v < lo) begin
         s.value = 32'sh8000_0000;
         s.ovf   = 1'b1;
      end else begin
         s.value = v[31:0];
         s.ovf   = 1'b0;
      end
      return s;
   endfunction

endpackage

### hw/rtl/wcm_front.sv
// Request intake: decode, classify and queue commands for the engine.
module wcm_front #(
   parameter int GROUP_SIZE = wcm_pkg::GROUP_SIZE_DEF,
   parameter int GENUS = wcm_pkg::GENUS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [31:0]      req_tdata,  // coef_row, coef_col, coef_value, data_value, pad
   input  logic [1:0]       req_tuser,  // opcode
   output logic             cmd_valid,
   output wcm_pkg::cmd_type cmd,
   input  logic             cmd_pop
);

   localparam int WinLen = GROUP_SIZE * GENUS;

   wcm_pkg::opcode_type op;
   wcm_pkg::cmd_type    cmd_w;
   logic                keep;
   logic                push;
   wcm_pkg::cmd_type    q_ff [2];
   logic                wr_ff, wr_in;
   logic                rd_ff, rd_in;
   logic [1:0]          count_ff, count_in;

   always_comb begin
      op = wcm_pkg::opcode_type'(req_tuser);
      cmd_w.row  = req_tdata[1:0];
      cmd_w.col  = req_tdata[5:2];
      cmd_w.cval = req_tdata[13:6];
      cmd_w.dval = req_tdata[29:14];
      cmd_w.kind = wcm_pkg::CMD_LOAD;
      keep = 1'b0;
      unique case (op)
         wcm_pkg::OP_LOAD: begin
            keep = ({6'd0, cmd_w.row} < 8'(GROUP_SIZE)) && ({4'd0, cmd_w.col} < 8'(WinLen));
         end
         wcm_pkg::OP_DATA: begin
            cmd_w.kind = wcm_pkg::CMD_DATA;
            keep = 1'b1;
         end
         wcm_pkg::OP_FLUSH: begin
            cmd_w.kind = wcm_pkg::CMD_FLUSH;
            keep = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_tready = (count_ff != 2'd2);
   assign push = req_tvalid && req_tready && keep;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd = q_ff[rd_ff];

   always_comb begin
      wr_in = push ? ~wr_ff : wr_ff;
      rd_in = cmd_pop ? ~rd_ff : rd_ff;
      count_in = 2'(count_ff + {1'b0, push} - {1'b0, cmd_pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= cmd_w;
      end
   end

endmodule

### hw/rtl/wcm_back.sv
// Engine: coefficient memory, shared MAC, overlap/sample window and result register.
module wcm_back #(
   parameter int GROUP_SIZE = wcm_pkg::GROUP_SIZE_DEF,
   parameter int GENUS = wcm_pkg::GENUS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic             csr_wdata,
   input  logic             cmd_valid,
   input  wcm_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [31:0]      rsp_tdata,  // result_value
   output logic             rsp_tlast,
   output logic             rsp_tuser   // overflow
);

   localparam int W = GROUP_SIZE * GENUS;
   localparam int RW = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
   localparam int CW = (W > 1) ? $clog2(W) : 1;
   localparam int AW = RW + CW;
   localparam int CNT_W = $clog2(W + 1);
   localparam int ACC_W = wcm_pkg::ACC_W;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_MAC   = 5'b00010,
      S_DRAIN = 5'b00100,
      S_FIN   = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   logic                    mode_ff, mode_in;
   logic signed [15:0]      gb_ff [GROUP_SIZE];
   logic signed [15:0]      gb_in [GROUP_SIZE];
   logic signed [31:0]      win_ff [W];
   logic signed [31:0]      win_in [W];
   logic                    wovf_ff [W];
   logic                    wovf_in [W];
   logic [RW-1:0]           gp_ff, gp_in;
   logic [CNT_W-1:0]        sc_ff, sc_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic                    flush_ff, flush_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    pv_ff, pv_in;
   logic signed [7:0]       rdata_ff;
   logic signed [15:0]      opnd_ff, opnd_in;
   logic signed [7:0]       coef_mem [2**AW];
   logic [AW-1:0]           raddr;
   logic [AW-1:0]           waddr;
   logic                    mem_we;
   logic signed [23:0]      prod;
   wcm_pkg::sat_type        sat_r;
   logic [CNT_W-1:0]        lim;
   logic                    clear_dp;
   logic                    out_free;
   logic                    out_load;
   logic signed [31:0]      out_value;
   logic                    out_last;
   logic                    out_ovf;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [31:0]             rsp_data_ff;
   logic                    rsp_last_ff;
   logic                    rsp_ovf_ff;

   assign prod = rdata_ff * opnd_ff;
   assign waddr = {RW'({6'd0, cmd.row}), CW'({2'd0, cmd.col})};
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign lim = mode_ff ? CNT_W'(W) : CNT_W'(GROUP_SIZE);
   assign sat_r = wcm_pkg::sat32(mode_ff ? acc_ff : (ACC_W'(win_ff[0]) + acc_ff));
   assign raddr = mode_ff ? {idx_ff[RW-1:0], cnt_ff} : {cnt_ff[RW-1:0], idx_ff};

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      gb_in = gb_ff;
      win_in = win_ff;
      wovf_in = wovf_ff;
      gp_in = gp_ff;
      sc_in = sc_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      n_in = n_ff;
      flush_in = flush_ff;
      acc_in = acc_ff;
      pv_in = 1'b0;
      opnd_in = opnd_ff;
      mem_we = 1'b0;
      cmd_pop = 1'b0;
      clear_dp = 1'b0;
      out_load = 1'b0;
      out_value = win_ff[0];
      out_last = 1'b0;
      out_ovf = wovf_ff[0];

      if (pv_ff) begin
         acc_in = acc_ff + ACC_W'(prod);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               unique case (cmd.kind)
                  wcm_pkg::CMD_LOAD: mem_we = 1'b1;
                  wcm_pkg::CMD_DATA: begin
                     if (!mode_ff) begin
                        gb_in[gp_ff] = cmd.dval;
                        if (gp_ff == RW'(GROUP_SIZE - 1)) begin
                           gp_in = '0;
                           idx_in = '0;
                           cnt_in = '0;
                           acc_in = '0;
                           n_in = CNT_W'(GROUP_SIZE);
                           flush_in = 1'b0;
                           state_in = S_MAC;
                        end else begin
                           gp_in = gp_ff + 1'b1;
                        end
                     end else begin
                        for (int i = 0; i < W - 1; i++) begin
                           win_in[i] = win_ff[i + 1];
                        end
                        win_in[W-1] = 32'(cmd.dval);
                        if (sc_ff != CNT_W'(W)) begin
                           sc_in = sc_ff + 1'b1;
                        end
                        gp_in = (gp_ff == RW'(GROUP_SIZE - 1)) ? '0 : gp_ff + 1'b1;
                        if (gp_ff == RW'(GROUP_SIZE - 1) && sc_ff >= CNT_W'(W - 1)) begin
                           idx_in = '0;
                           cnt_in = '0;
                           acc_in = '0;
                           state_in = S_MAC;
                        end
                     end
                  end
                  wcm_pkg::CMD_FLUSH: begin
                     if (mode_ff) begin
                        clear_dp = 1'b1;
                     end else if (gp_ff != '0) begin
                        idx_in = '0;
                        cnt_in = '0;
                        acc_in = '0;
                        n_in = CNT_W'(W);
                        flush_in = 1'b1;
                        state_in = S_MAC;
                     end else if (W == GROUP_SIZE) begin
                        clear_dp = 1'b1;
                     end else begin
                        cnt_in = '0;
                        n_in = CNT_W'(W - GROUP_SIZE);
                        flush_in = 1'b1;
                        state_in = S_EMIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_MAC: begin
            pv_in = 1'b1;
            if (mode_ff) begin
               opnd_in = win_ff[0][15:0];
               for (int i = 0; i < W - 1; i++) begin
                  win_in[i] = win_ff[i + 1];
               end
               win_in[W-1] = win_ff[0];
            end else begin
               opnd_in = gb_ff[cnt_ff[RW-1:0]];
            end
            if (CNT_W'(cnt_ff) == lim - 1'b1) begin
               state_in = S_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DRAIN: state_in = S_FIN;
         S_FIN: begin
            if (!mode_ff) begin
               for (int i = 0; i < W - 1; i++) begin
                  win_in[i] = win_ff[i + 1];
                  wovf_in[i] = wovf_ff[i + 1];
               end
               win_in[W-1] = sat_r.value;
               wovf_in[W-1] = wovf_ff[0] | sat_r.ovf;
               cnt_in = '0;
               acc_in = '0;
               if (idx_ff == CW'(W - 1)) begin
                  for (int i = 0; i < GROUP_SIZE; i++) begin
                     gb_in[i] = '0;
                  end
                  state_in = S_EMIT;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = S_MAC;
               end
            end else if (out_free) begin
               out_load = 1'b1;
               out_value = sat_r.value;
               out_ovf = sat_r.ovf;
               out_last = (idx_ff == CW'(GROUP_SIZE - 1));
               cnt_in = '0;
               acc_in = '0;
               if (out_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = S_MAC;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_last = (CNT_W'(cnt_ff) == n_ff - 1'b1);
               for (int i = 0; i < W - 1; i++) begin
                  win_in[i] = win_ff[i + 1];
                  wovf_in[i] = wovf_ff[i + 1];
               end
               win_in[W-1] = '0;
               wovf_in[W-1] = 1'b0;
               cnt_in = cnt_ff + 1'b1;
               if (out_last) begin
                  state_in = S_IDLE;
                  clear_dp = flush_ff;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_we) begin
         mode_in = csr_wdata;
         clear_dp = 1'b1;
      end

      if (clear_dp) begin
         for (int i = 0; i < GROUP_SIZE; i++) begin
            gb_in[i] = '0;
         end
         for (int i = 0; i < W; i++) begin
            win_in[i] = '0;
            wovf_in[i] = 1'b0;
         end
         gp_in = '0;
         sc_in = '0;
      end

      rsp_valid_in = (rsp_valid_ff && !rsp_tready) || out_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff <= 1'b0;
         for (int i = 0; i < GROUP_SIZE; i++) begin
            gb_ff[i] <= '0;
         end
         for (int i = 0; i < W; i++) begin
            win_ff[i] <= '0;
            wovf_ff[i] <= 1'b0;
         end
         gp_ff <= '0;
         sc_ff <= '0;
         cnt_ff <= '0;
         idx_ff <= '0;
         n_ff <= '0;
         flush_ff <= 1'b0;
         pv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         gb_ff <= gb_in;
         win_ff <= win_in;
         wovf_ff <= wovf_in;
         gp_ff <= gp_in;
         sc_ff <= sc_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
         n_ff <= n_in;
         flush_ff <= flush_in;
         pv_ff <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      opnd_ff <= opnd_in;
      if (out_load) begin
         rsp_data_ff <= out_value;
         rsp_last_ff <= out_last;
         rsp_ovf_ff <= out_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         coef_mem[waddr] <= cmd.cval;
      end
      rdata_ff <= coef_mem[raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tuser = rsp_ovf_ff;

`ifndef SYNTHESIS
   a_sc_bound: assert property (@(posedge clock) disable iff (reset)
      sc_ff <= CNT_W'(W)) else $error("sample count beyond window");
   a_gp_bound: assert property (@(posedge clock) disable iff (reset)
      gp_ff <= RW'(GROUP_SIZE - 1)) else $error("group position out of range");
   a_emit_enc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> !mode_ff) else $error("window emit in decode mode");
   a_pv_mac: assert property (@(posedge clock) disable iff (reset)
      pv_ff |-> $past(state_ff == S_MAC)) else $error("product without read");
`endif

endmodule

### hw/rtl/wavelet_coding_modem_top.sv
// Top level of the wavelet coding modem: request front end and MAC engine.
// Encode: a full group runs one MAC pass over the group for each window column, then emits M results;
// the single shared MAC sets the throughput, and the engine pops no new request until it is done.
// Decode: each emitting group runs one MAC pass over the window for each result row; others take only intake.
// Up to two requests queue ahead of the engine; results leave through one register.
// Synchronous active-high reset clears control, window and mode; coefficients are not cleared.
module wavelet_coding_modem_top #(
   parameter int GROUP_SIZE = wcm_pkg::GROUP_SIZE_DEF,
   parameter int GENUS = wcm_pkg::GENUS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // coef_row, coef_col, coef_value, data_value, pad
   input  logic [1:0]  req_tuser,  // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // result_value
   output logic        rsp_tlast,
   output logic        rsp_tuser   // overflow
);

   logic             cmd_valid;
   wcm_pkg::cmd_type cmd;
   logic             cmd_pop;

   wcm_front #(
      .GROUP_SIZE(GROUP_SIZE),
      .GENUS(GENUS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .cmd_valid(cmd_valid),
      .cmd(cmd),
      .cmd_pop(cmd_pop)
   );

   wcm_back #(
      .GROUP_SIZE(GROUP_SIZE),
      .GENUS(GENUS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .cmd_valid(cmd_valid),
      .cmd(cmd),
      .cmd_pop(cmd_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

endmodule

### dv/tb_top.sv
// Self-checking testbench for the wavelet coding modem top level.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int M = wcm_pkg::GROUP_SIZE_DEF;
   localparam int WIN = wcm_pkg::GROUP_SIZE_DEF * wcm_pkg::GENUS_DEF;
   localparam longint CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      logic signed [31:0] value;
      bit                 last;
      bit                 ovf;
   } coded_type;

   typedef struct {
      wcm_pkg::opcode_type op;
      logic [1:0]          row;
      logic [3:0]          col;
      logic signed [7:0]   cv;
      logic signed [15:0]  dv;
      int                  n_out;
   } stim_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;  // coef_row, coef_col, coef_value, data_value, pad
   logic [1:0]  req_tuser;  // opcode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;  // result_value
   logic        rsp_tlast;
   logic        rsp_tuser;  // overflow

   coded_type          coded_q[$];
   logic signed [7:0]  coef_mem[M][WIN];
   longint             sym_buf[M];
   longint             win_acc[WIN];
   bit                 win_ovf[WIN];
   int                 grp_pos;
   int                 samp_cnt;
   bit                 cur_mode;
   int                 error_count;
   int                 accepted_requests;
   int                 snd_idle_pct;
   int                 rcv_idle_pct;
   int                 hold_left;
   bit                 hold_done;
   longint             cycle_count = 0;

   wavelet_coding_modem_top dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic longint clamp32(input longint v, inout bit ovf);
      if (v > 64'sd2147483647) begin
         ovf = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         ovf = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic void push_coded(input longint v, input bit l, input bit o);
      coded_type c;
      c.value = v[31:0];
      c.last  = l;
      c.ovf   = o;
      coded_q.push_back(c);
   endfunction

   function automatic void clear_datapath();
      for (int j = 0; j < WIN; j++) begin
         win_acc[j] = 0;
         win_ovf[j] = 1'b0;
      end
      for (int r = 0; r < M; r++) sym_buf[r] = 0;
      grp_pos  = 0;
      samp_cnt = 0;
   endfunction

   function automatic void encode_group(input bit last_at_end);
      longint acc;
      bit     o;
      for (int j = 0; j < WIN; j++) begin
         acc = 0;
         o   = 1'b0;
         for (int r = 0; r < M; r++) acc += sym_buf[r] * longint'(coef_mem[r][j]);
         win_acc[j] = clamp32(win_acc[j] + acc, o);
         win_ovf[j] = win_ovf[j] | o;
      end
      for (int j = 0; j < M; j++) push_coded(win_acc[j], last_at_end && j == M - 1, win_ovf[j]);
      for (int j = 0; j < WIN; j++) begin
         if (j + M < WIN) begin
            win_acc[j] = win_acc[j + M];
            win_ovf[j] = win_ovf[j + M];
         end else begin
            win_acc[j] = 0;
            win_ovf[j] = 1'b0;
         end
      end
      for (int r = 0; r < M; r++) sym_buf[r] = 0;
      grp_pos = 0;
   endfunction

   function automatic void modem_predict(input stim_type s);
      longint acc;
      bit     o;
      if (s.op == wcm_pkg::OP_LOAD) begin
         if (s.row < M && s.col < WIN) coef_mem[s.row][s.col] = s.cv;
         return;
      end
      if (s.op == wcm_pkg::OP_NONE) return;
      if (!cur_mode) begin
         if (s.op == wcm_pkg::OP_DATA) begin
            sym_buf[grp_pos] = s.dv;
            grp_pos = (grp_pos + 1) % M;
            if (grp_pos == 0) encode_group(1'b1);
         end else begin
            if (grp_pos != 0) encode_group(WIN == M);
            for (int j = 0; j + M < WIN; j++) push_coded(win_acc[j], j + M == WIN - 1, win_ovf[j]);
            clear_datapath();
         end
         return;
      end
      if (s.op == wcm_pkg::OP_FLUSH) begin
         clear_datapath();
         return;
      end
      for (int j = 0; j + 1 < WIN; j++) win_acc[j] = win_acc[j + 1];
      win_acc[WIN - 1] = s.dv;
      if (samp_cnt < WIN) samp_cnt++;
      grp_pos = (grp_pos + 1) % M;
      if (grp_pos == 0 && samp_cnt >= WIN) begin
         for (int r = 0; r < M; r++) begin
            acc = 0;
            o   = 1'b0;
            for (int j = 0; j < WIN; j++) acc += longint'(coef_mem[r][j]) * win_acc[j];
            acc = clamp32(acc, o);
            push_coded(acc, r == M - 1, o);
         end
      end
   endfunction

   task automatic send_request(input stim_type s);
      int prev_size;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= s.op;
      req_tdata  <= {2'b00, s.dv, s.cv, s.col, s.row};
      do @(posedge clock); while (!req_tready);
      prev_size = coded_q.size();
      modem_predict(s);
      accepted_requests++;
      if (s.n_out >= 0 && coded_q.size() - prev_size != s.n_out)
         report_mismatch($sformatf("request %0d: %0d results predicted, %0d listed",
                                   accepted_requests, coded_q.size() - prev_size, s.n_out));
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (coded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input bit m);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_mode = m;
      clear_datapath();
   endtask

   function automatic stim_type random_request();
      stim_type s;
      int       pick;
      pick    = $urandom_range(99);
      s.op    = pick < 80 ? wcm_pkg::OP_DATA : pick < 88 ? wcm_pkg::OP_FLUSH :
                pick < 96 ? wcm_pkg::OP_LOAD : wcm_pkg::OP_NONE;
      s.row   = 2'($urandom_range(3));
      s.col   = 4'($urandom_range(15));
      s.cv    = 8'($urandom);
      s.dv    = 16'($urandom);
      if ($urandom_range(9) == 0) s.dv = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      s.n_out = -1;
      return s;
   endfunction

   task automatic random_phase(input int n, input int sp, input int rp);
      snd_idle_pct = sp;
      rcv_idle_pct = rp;
      repeat (n) send_request(random_request());
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         hold_done  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && accepted_requests >= 150) begin
         hold_left  <= 400;
         hold_done  <= 1'b1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(99) >= rcv_idle_pct;
      end
   end

   always @(posedge clock) begin
      coded_type c;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (coded_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", rsp_tdata));
         end else begin
            c = coded_q.pop_front();
            if (rsp_tdata !== c.value)
               report_mismatch($sformatf("value %h, want %h", rsp_tdata, c.value));
            if (rsp_tlast !== c.last)
               report_mismatch($sformatf("last %b, want %b", rsp_tlast, c.last));
            if (rsp_tuser !== c.ovf)
               report_mismatch($sformatf("overflow %b, want %b", rsp_tuser, c.ovf));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      stim_type directed[] = '{
         '{wcm_pkg::OP_FLUSH, 2'd0, 4'd0,  8'sd0,    16'sd0,      12},
         '{wcm_pkg::OP_NONE,  2'd3, 4'd15, 8'sh7F,   16'sh7FFF,   0},
         '{wcm_pkg::OP_LOAD,  2'd3, 4'd15, -8'sd128, 16'sd0,      0},
         '{wcm_pkg::OP_LOAD,  2'd0, 4'd0,  8'sd127,  16'sh7FFF,   0},
         '{wcm_pkg::OP_DATA,  2'd0, 4'd0,  8'sd0,    16'sh7FFF,   0},
         '{wcm_pkg::OP_DATA,  2'd0, 4'd0,  8'sd0,    16'sh8000,   0},
         '{wcm_pkg::OP_DATA,  2'd0, 4'd0,  8'sd0,    16'sh7FFF,   0},
         '{wcm_pkg::OP_DATA,  2'd0, 4'd0,  8'sd0,    16'sh8000,   4},
         '{wcm_pkg::OP_DATA,  2'd0, 4'd0,  8'sd0,    -16'sd1,     0},
         '{wcm_pkg::OP_DATA,  2'd0, 4'd0,  8'sd0,    16'sd0,      0},
         '{wcm_pkg::OP_FLUSH, 2'd0, 4'd0,  8'sd0,    16'sd0,      16},
         '{wcm_pkg::OP_DATA,  2'd0, 4'd0,  8'sd0,    16'sd1,      0},
         '{wcm_pkg::OP_DATA,  2'd0, 4'd0,  8'sd0,    16'sd2,      0},
         '{wcm_pkg::OP_DATA,  2'd0, 4'd0,  8'sd0,    16'sd3,      0},
         '{wcm_pkg::OP_FLUSH, 2'd0, 4'd0,  8'sd0,    16'sd0,      16},
         '{wcm_pkg::OP_FLUSH, 2'd0, 4'd0,  8'sd0,    16'sd0,      12}
      };
      stim_type s;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_wdata         = 1'b0;
      req_tvalid        = 1'b0;
      req_tdata         = '0;
      req_tuser         = wcm_pkg::OP_NONE;
      error_count       = 0;
      accepted_requests = 0;
      snd_idle_pct      = 0;
      rcv_idle_pct      = 0;
      cur_mode          = 1'b0;
      clear_datapath();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_mode(1'b0);
      for (int r = 0; r < M; r++) begin
         for (int c = 0; c < WIN; c++) begin
            s.op    = wcm_pkg::OP_LOAD;
            s.row   = 2'(r);
            s.col   = 4'(c);
            s.cv    = (r + c) % 5 == 0 ? -8'sd128 : (r + c) % 5 == 1 ? 8'sd127 : 8'($urandom);
            s.dv    = 16'($urandom);
            s.n_out = 0;
            send_request(s);
         end
      end
      foreach (directed[i]) send_request(directed[i]);
      random_phase(85, 19, 80);
      write_mode(1'b1);
      random_phase(85, 80, 19);
      write_mode(1'b0);
      random_phase(85, 0, 0);
      write_mode(1'b1);
      random_phase(85, 0, 0);
      settle();
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

### files.f
hw/rtl/wcm_pkg.sv
hw/rtl/wcm_front.sv
hw/rtl/wcm_back.sv
hw/rtl/wavelet_coding_modem_top.sv
dv/tb_top.sv
